/* sv/upsf_pkg.sv */
package upsf_pkg;

   // UTF-8 lead and continuation bytes recognized by the filter
   localparam logic [7:0] LEAD_C2   = 8'hC2;
   localparam logic [7:0] LEAD_C3   = 8'hC3;
   localparam logic [7:0] LEAD_E2   = 8'hE2;
   localparam logic [7:0] LEAD_E3   = 8'hE3;
   localparam logic [7:0] LEAD_EF   = 8'hEF;
   localparam logic [7:0] CONT_80   = 8'h80;
   localparam logic [7:0] CONT_81   = 8'h81;
   localparam logic [7:0] CONT_90   = 8'h90;
   localparam logic [7:0] CONT_97   = 8'h97;
   localparam logic [7:0] CONT_9E   = 8'h9E;
   localparam logic [7:0] CONT_A0   = 8'hA0;
   localparam logic [7:0] CONT_AF   = 8'hAF;
   localparam logic [7:0] CONT_B7   = 8'hB7;
   localparam logic [7:0] CONT_B9   = 8'hB9;
   localparam logic [7:0] CONT_BC   = 8'hBC;
   localparam logic [7:0] CONT_BD   = 8'hBD;
   localparam logic [7:0] CONT_BF   = 8'hBF;

   // offsets from the last fullwidth byte to its halfwidth ASCII code
   localparam logic [7:0] HALF_OFS_BC = 8'h60;
   localparam logic [7:0] HALF_OFS_BD = 8'h20;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int MAX_PUSH   = 3;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      logic        end_mark;
      logic [15:0] kept_count;
   } rsp_entry_type;

   // results produced by one item, entry 0 first
   typedef struct packed {
      logic [1:0]                  count;
      rsp_entry_type [MAX_PUSH-1:0] entry;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] used;
      logic       emit;
      logic [7:0] ob;
   } decide_type;

   function automatic logic is_punct(input logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c, input logic fold);
      if (fold && c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   // Decide the byte at the head of the window; rem is the byte count present (1..3)
   function automatic decide_type decide(input logic [7:0] h, input logic [7:0] c1,
                                         input logic [7:0] c2, input logic [1:0] rem,
                                         input logic last, input logic fold);
      decide_type d;
      logic [1:0] need;
      logic       has1;
      logic       has2;
      logic       drop2;
      logic       drop3;
      logic       conv;
      logic [7:0] half;
      if (h == LEAD_C2 || h == LEAD_C3) begin
         need = 2'd1;
      end else if (h == LEAD_E2 || h == LEAD_E3 || h == LEAD_EF) begin
         need = 2'd2;
      end else begin
         need = 2'd0;
      end
      has1  = rem >= 2'd2;
      has2  = rem == 2'd3;
      drop2 = has1 && ((h == LEAD_C2 && c1 >= CONT_A0 && c1 <= CONT_BF) ||
                       (h == LEAD_C3 && (c1 == CONT_97 || c1 == CONT_B7)));
      drop3 = has2 && ((h == LEAD_E2 && c1 == CONT_80 && c2 >= CONT_80 && c2 <= CONT_BF) ||
                       (h == LEAD_E2 && c1 == CONT_81 && c2 >= CONT_80 && c2 <= CONT_AF) ||
                       (h == LEAD_E3 && c1 == CONT_80 && c2 >= CONT_80 && c2 <= CONT_BF) ||
                       (h == LEAD_EF && c1 == CONT_B9 && c2 >= CONT_90 && c2 <= CONT_AF));
      conv  = has2 && h == LEAD_EF &&
              ((c1 == CONT_BC && c2 >= CONT_81 && c2 <= CONT_BF) ||
               (c1 == CONT_BD && c2 >= CONT_80 && c2 <= CONT_9E));
      half  = (c1 == CONT_BC) ? c2 - HALF_OFS_BC : c2 - HALF_OFS_BD;
      d.ok   = last || (rem > need);
      d.used = 2'd1;
      d.emit = 1'b0;
      d.ob   = '0;
      if (drop2) begin
         d.used = 2'd2;
      end else if (drop3) begin
         d.used = 2'd3;
      end else if (conv) begin
         d.used = 2'd3;
         if (!is_punct(half)) begin
            d.emit = 1'b1;
            d.ob   = fold_case(half, fold);
         end
      end else if (!is_punct(h)) begin
         d.emit = 1'b1;
         d.ob   = fold_case(h, fold);
      end
      return d;
   endfunction

endpackage

/* sv/upsf_channels.sv */
// Input byte channel
interface upsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Result channel
interface upsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        out_valid;
   logic        end_mark;
   logic [15:0] kept_count;
   modport source (output valid, output out_byte, output out_valid, output end_mark,
                   output kept_count, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input end_mark,
                   input kept_count, output ready);
endinterface

// Register write channel
interface upsf_csr_if;
   logic valid;
   logic ready;
   logic fold_upper;
   modport source (output valid, output fold_upper, input ready);
   modport sink   (input valid, input fold_upper, output ready);
endinterface

/* sv/upsf_window.sv */
module upsf_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   input  logic                fold,
   output upsf_pkg::push_type  push
);

   logic [7:0]  win0_ff, win0_in;
   logic [7:0]  win1_ff, win1_in;
   logic [1:0]  fill_ff, fill_in;
   logic [15:0] total_ff, total_in;

   logic [7:0]           b0, b1, b2;
   logic [2:0]           avail;
   logic [2:0]           pos;
   logic [1:0]           n;
   logic [15:0]          cnt;
   logic                 active;
   upsf_pkg::decide_type d;
   upsf_pkg::push_type   res;

   function automatic logic [7:0] pick(input logic [2:0] idx, input logic [7:0] x0,
                                       input logic [7:0] x1, input logic [7:0] x2);
      case (idx)
         3'd0:    return x0;
         3'd1:    return x1;
         3'd2:    return x2;
         default: return 8'h00;
      endcase
   endfunction

   // assemble the window: held bytes then the new byte
   always_comb begin
      case (fill_ff)
         2'd0: begin
            b0 = in_byte; b1 = 8'h00; b2 = 8'h00;
         end
         2'd1: begin
            b0 = win0_ff; b1 = in_byte; b2 = 8'h00;
         end
         default: begin
            b0 = win0_ff; b1 = win1_ff; b2 = in_byte;
         end
      endcase
      avail = {1'b0, fill_ff} + 3'd1;
   end

   // up to three decisions, each starting where the previous one ended
   always_comb begin
      pos    = 3'd0;
      n      = 2'd0;
      cnt    = total_ff;
      active = 1'b1;
      res    = '0;
      d      = '0;
      for (int k = 0; k < upsf_pkg::MAX_PUSH; k++) begin
         if (active && pos < avail) begin
            d = upsf_pkg::decide(pick(pos, b0, b1, b2), pick(pos + 3'd1, b0, b1, b2),
                                 pick(pos + 3'd2, b0, b1, b2), 2'(avail - pos),
                                 in_last, fold);
            if (d.ok) begin
               pos = pos + {1'b0, d.used};
               if (d.emit) begin
                  if (cnt != upsf_pkg::COUNT_MAX) begin
                     cnt = cnt + 16'd1;
                  end
                  res.entry[n].out_byte   = d.ob;
                  res.entry[n].out_valid  = 1'b1;
                  res.entry[n].end_mark   = 1'b0;
                  res.entry[n].kept_count = cnt;
                  n = n + 2'd1;
               end
            end else begin
               active = 1'b0;
            end
         end else begin
            active = 1'b0;
         end
      end
      // end of string: mark the final result, or send a bare marker
      if (in_last) begin
         if (n == 2'd0) begin
            res.entry[0].out_byte   = 8'h00;
            res.entry[0].out_valid  = 1'b0;
            res.entry[0].end_mark   = 1'b1;
            res.entry[0].kept_count = cnt;
            n = 2'd1;
         end else begin
            res.entry[n - 2'd1].end_mark = 1'b1;
         end
      end
      res.count = go ? n : 2'd0;
   end

   assign push = res;

   // next window and count
   always_comb begin
      win0_in  = win0_ff;
      win1_in  = win1_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      if (go) begin
         if (in_last) begin
            win0_in  = 8'h00;
            win1_in  = 8'h00;
            fill_in  = 2'd0;
            total_in = 16'd0;
         end else begin
            win0_in  = pick(pos, b0, b1, b2);
            win1_in  = pick(pos + 3'd1, b0, b1, b2);
            fill_in  = 2'(avail - pos);
            total_in = cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff  <= 8'h00;
         win1_ff  <= 8'h00;
         fill_ff  <= 2'd0;
         total_ff <= 16'd0;
      end else begin
         win0_ff  <= win0_in;
         win1_ff  <= win1_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("window holds more than two bytes");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      go && in_last |=> fill_ff == 2'd0 && total_ff == 16'd0)
      else $error("window or count not cleared after end of string");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      go && in_last |-> push.count != 2'd0 && push.entry[push.count - 2'd1].end_mark)
      else $error("end of string without a marked result");

endmodule

/* sv/upsf_rsp_fifo.sv */
module upsf_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  upsf_pkg::push_type push,
   output logic               room,
   upsf_rsp_if.source         rsp
);

   localparam int AW = upsf_pkg::FIFO_AW;
   localparam int CW = upsf_pkg::FIFO_CW;

   upsf_pkg::rsp_entry_type mem_ff [upsf_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   upsf_pkg::rsp_entry_type head;

   // room for a full burst from one item
   assign room = count_ff <= CW'(upsf_pkg::FIFO_DEPTH - upsf_pkg::MAX_PUSH);
   assign pop  = rsp.valid && rsp.ready;

   assign head           = mem_ff[rd_ptr_ff];
   assign rsp.valid      = count_ff != '0;
   assign rsp.out_byte   = head.out_byte;
   assign rsp.out_valid  = head.out_valid;
   assign rsp.end_mark   = head.end_mark;
   assign rsp.kept_count = head.kept_count;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push.count);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   // queue storage
   always_ff @(posedge clock) begin
      for (int k = 0; k < upsf_pkg::MAX_PUSH; k++) begin
         if (2'(k) < push.count) begin
            mem_ff[wr_ptr_ff + AW'(k)] <= push.entry[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(upsf_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("results pushed without room");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      AW'(wr_ptr_ff - rd_ptr_ff) == AW'(count_ff))
      else $error("queue pointers disagree with count");

endmodule

/* sv/utf8_punct_strip_filter_unit.sv */
// UTF-8 punctuation strip filter. Takes one string byte per item on req and
// returns one result per kept byte on rsp (plus a bare end marker when the
// final byte keeps nothing). A byte accepted on req passes through an input
// register, then the window decision, which writes up to three results into
// an eight-entry result queue. The queue sets the rate: one byte is accepted
// per cycle while it holds five results or fewer, and it drains one result
// per cycle while rsp is ready, so sustained throughput is one byte per cycle
// unless a byte frees a window that yields two or three kept bytes.
// fold_upper resets to 1 and is written through csr, which is always ready.
module utf8_punct_strip_filter_unit (
   input  logic       clock,
   input  logic       reset,
   upsf_req_if.sink   req,
   upsf_rsp_if.source rsp,
   upsf_csr_if.sink   csr
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;
   logic       fold_ff, fold_in;
   logic       room;
   logic       go;

   upsf_pkg::push_type push;

   // stage 1 advances into the window whenever the queue has room
   assign go        = s1_valid_ff && room;
   assign req.ready = !s1_valid_ff || go;
   assign csr.ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req.valid && req.ready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req.in_byte;
         s1_last_in  = req.in_last;
      end else if (go) begin
         s1_valid_in = 1'b0;
      end
      fold_in = (csr.valid && csr.ready) ? csr.fold_upper : fold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fold_ff     <= 1'b1;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fold_ff     <= fold_in;
      end
   end

   // item payload register
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
   end

   upsf_window u_window (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .in_byte (s1_byte_ff),
      .in_last (s1_last_ff),
      .fold    (fold_ff),
      .push    (push)
   );

   upsf_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp)
   );

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !room |-> !req.ready)
      else $error("input taken while stage 1 is blocked");

   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      go |-> push.count != 2'd0 || !s1_last_ff)
      else $error("end of string produced no result");

   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !go |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("stalled item lost from stage 1");

endmodule
